// ===== rtl/core/dqu_pkg.sv =====
// Shared constants, codes and types for the double-ended queue unit.
package dqu_pkg;

   localparam int DEPTH       = 16;
   localparam int DATA_WIDTH  = 32;
   localparam int IDX_WIDTH   = $clog2(DEPTH);
   localparam int COUNT_WIDTH = $clog2(DEPTH + 1);

   localparam logic [2:0] ACT_PUSH_TAIL = 3'd0;
   localparam logic [2:0] ACT_PUSH_HEAD = 3'd1;
   localparam logic [2:0] ACT_POP_TAIL  = 3'd2;
   localparam logic [2:0] ACT_POP_HEAD  = 3'd3;
   localparam logic [2:0] ACT_PEEK_TAIL = 3'd4;
   localparam logic [2:0] ACT_PEEK_HEAD = 3'd5;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_UNDERFLOW = 2'd1;
   localparam logic [1:0] ST_OVERFLOW  = 2'd2;

   typedef logic [DATA_WIDTH-1:0] elem_type;

   typedef struct packed {
      logic shift_r;
      logic shift_l;
   } shift_ctl_type;

endpackage

// ===== rtl/core/dqu_cell.sv =====
// One cell of the deque row: holds one element, loaded or taken from a neighbor.
module dqu_cell (
   input  logic                  clock,
   input  dqu_pkg::shift_ctl_type ctl,
   input  logic                  load_en,
   input  dqu_pkg::elem_type     load_data,
   input  dqu_pkg::elem_type     left_data,
   input  dqu_pkg::elem_type     right_data,
   output dqu_pkg::elem_type     cell_data
);

   dqu_pkg::elem_type cell_data_ff;
   dqu_pkg::elem_type cell_data_in;

   always_comb begin
      cell_data_in = cell_data_ff;
      if (ctl.shift_r) begin
         cell_data_in = left_data;
      end else if (ctl.shift_l) begin
         cell_data_in = right_data;
      end else if (load_en) begin
         cell_data_in = load_data;
      end
   end

   always_ff @(posedge clock) begin
      cell_data_ff <= cell_data_in;
   end

   assign cell_data = cell_data_ff;

endmodule

// ===== rtl/core/double_ended_queue_unit.sv =====
// Top level of the double-ended queue unit: control, count and a row of shifting cells.
// An accepted request's response is registered and shows in the cycle after acceptance.
// Throughput: one request per cycle; a stalled response blocks requests until taken.
// Elements live in a row of cells, head in cell 0; head pushes and pops shift the row.
// Reset clears the element count and the response valid; cell contents are not cleared.
module double_ended_queue_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [2:0]                     req_action,
   input  logic signed [31:0]             req_value,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic signed [31:0]             rsp_data,
   output logic [4:0]                     rsp_count,
   output logic                           rsp_empty_res,
   output logic [1:0]                     rsp_status
);

   localparam int DEPTH = dqu_pkg::DEPTH;

   logic [dqu_pkg::COUNT_WIDTH-1:0] count_ff;
   logic [dqu_pkg::COUNT_WIDTH-1:0] count_in;
   logic                            rsp_valid_ff;
   logic                            rsp_valid_in;
   logic signed [31:0]              rsp_data_ff;
   logic signed [31:0]              rsp_data_in;
   logic [4:0]                      rsp_count_ff;
   logic [4:0]                      rsp_count_in;
   logic                            rsp_empty_ff;
   logic                            rsp_empty_in;
   logic [1:0]                      rsp_status_ff;
   logic [1:0]                      rsp_status_in;

   logic                            accept;
   logic                            is_full;
   logic                            is_empty;
   logic                            push_tail;
   dqu_pkg::shift_ctl_type          ctl;
   dqu_pkg::elem_type               elem;
   dqu_pkg::elem_type               read_elem;
   logic [dqu_pkg::IDX_WIDTH-1:0]   tail_idx;
   dqu_pkg::elem_type               cell_q [DEPTH];

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;
   assign is_full   = (count_ff == dqu_pkg::COUNT_WIDTH'(DEPTH));
   assign is_empty  = (count_ff == '0);
   assign elem      = dqu_pkg::DATA_WIDTH'($unsigned(req_value));
   assign tail_idx  = dqu_pkg::IDX_WIDTH'(count_ff - 1'b1);

   always_comb begin
      count_in      = count_ff;
      ctl           = '0;
      push_tail     = 1'b0;
      read_elem     = '0;
      rsp_status_in = dqu_pkg::ST_OK;
      case (req_action)
         dqu_pkg::ACT_PUSH_TAIL, dqu_pkg::ACT_PUSH_HEAD: begin
            if (is_full) begin
               rsp_status_in = dqu_pkg::ST_OVERFLOW;
            end else begin
               count_in = count_ff + 1'b1;
               if (req_action == dqu_pkg::ACT_PUSH_TAIL) begin
                  push_tail = accept;
               end else begin
                  ctl.shift_r = accept;
               end
            end
         end
         dqu_pkg::ACT_POP_TAIL, dqu_pkg::ACT_PEEK_TAIL: begin
            if (is_empty) begin
               rsp_status_in = dqu_pkg::ST_UNDERFLOW;
            end else begin
               read_elem = cell_q[tail_idx];
               if (req_action == dqu_pkg::ACT_POP_TAIL) begin
                  count_in = count_ff - 1'b1;
               end
            end
         end
         dqu_pkg::ACT_POP_HEAD, dqu_pkg::ACT_PEEK_HEAD: begin
            if (is_empty) begin
               rsp_status_in = dqu_pkg::ST_UNDERFLOW;
            end else begin
               read_elem = cell_q[0];
               if (req_action == dqu_pkg::ACT_POP_HEAD) begin
                  count_in    = count_ff - 1'b1;
                  ctl.shift_l = accept;
               end
            end
         end
         default: begin
         end
      endcase
      rsp_data_in  = 32'(read_elem);
      rsp_count_in = 5'(count_in);
      rsp_empty_in = (count_in == '0);
      rsp_valid_in = accept | req_stall;
   end

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      dqu_pkg::elem_type left_data;
      dqu_pkg::elem_type right_data;
      if (i == 0) begin : g_first
         assign left_data = elem;
      end else begin : g_left
         assign left_data = cell_q[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
         assign right_data = cell_q[i];
      end else begin : g_right
         assign right_data = cell_q[i+1];
      end
      dqu_cell u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .load_en    (push_tail && (count_ff == dqu_pkg::COUNT_WIDTH'(i))),
         .load_data  (elem),
         .left_data  (left_data),
         .right_data (right_data),
         .cell_data  (cell_q[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            count_ff <= count_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff   <= rsp_data_in;
         rsp_count_ff  <= rsp_count_in;
         rsp_empty_ff  <= rsp_empty_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_data      = rsp_data_ff;
   assign rsp_count     = rsp_count_ff;
   assign rsp_empty_res = rsp_empty_ff;
   assign rsp_status    = rsp_status_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= dqu_pkg::COUNT_WIDTH'(DEPTH))
      else $error("element count exceeds depth");

   a_accept_rsp: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff && rsp_count_ff == 5'(count_ff))
      else $error("response missing or count mismatch after request");

   a_empty_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_empty_ff == (rsp_count_ff == 5'd0)))
      else $error("empty flag disagrees with count");

   a_overflow: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff == dqu_pkg::ST_OVERFLOW |->
         rsp_count_ff == 5'(DEPTH) && rsp_data_ff == '0)
      else $error("overflow reported while not full");

   a_underflow: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff == dqu_pkg::ST_UNDERFLOW |->
         rsp_empty_ff && rsp_data_ff == '0)
      else $error("underflow reported while not empty");

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the double-ended queue unit with a predicting scoreboard class.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLOCK_PERIOD = 10;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int HOLD_CYCLES  = 300;
   localparam int MAX_REPORTS  = 10;
   localparam int PHASE_ITEMS  = 500;

   localparam logic [2:0] ACT_SPARE_A = 3'd6;
   localparam logic [2:0] ACT_SPARE_B = 3'd7;

   typedef struct {
      logic signed [31:0] data;
      logic [4:0]         count;
      logic               empty_res;
      logic [1:0]         status;
   } reply_type;

   class deque_mirror;
      dqu_pkg::elem_type slots [dqu_pkg::DEPTH];
      int unsigned       head_at = 0;
      int unsigned       tail_at = 0;
      int unsigned       fill = 0;
      reply_type         awaited_replies [$];
      int                errors = 0;

      function void note_request(logic [2:0] action, logic signed [31:0] value);
         reply_type   r;
         int unsigned at;
         r.data = '0;
         r.status = dqu_pkg::ST_OK;
         case (action)
            dqu_pkg::ACT_PUSH_TAIL, dqu_pkg::ACT_PUSH_HEAD: begin
               if (fill >= dqu_pkg::DEPTH) begin
                  r.status = dqu_pkg::ST_OVERFLOW;
               end else if (action == dqu_pkg::ACT_PUSH_TAIL) begin
                  slots[tail_at] = value;
                  tail_at = (tail_at + 1) % dqu_pkg::DEPTH;
                  fill++;
               end else begin
                  head_at = (head_at + dqu_pkg::DEPTH - 1) % dqu_pkg::DEPTH;
                  slots[head_at] = value;
                  fill++;
               end
            end
            dqu_pkg::ACT_POP_TAIL, dqu_pkg::ACT_POP_HEAD,
            dqu_pkg::ACT_PEEK_TAIL, dqu_pkg::ACT_PEEK_HEAD: begin
               if (fill == 0) begin
                  r.status = dqu_pkg::ST_UNDERFLOW;
               end else begin
                  at = (action == dqu_pkg::ACT_POP_TAIL || action == dqu_pkg::ACT_PEEK_TAIL) ?
                       (tail_at + dqu_pkg::DEPTH - 1) % dqu_pkg::DEPTH : head_at;
                  r.data = slots[at];
                  if (action == dqu_pkg::ACT_POP_TAIL) begin
                     tail_at = at;
                     fill--;
                  end else if (action == dqu_pkg::ACT_POP_HEAD) begin
                     head_at = (head_at + 1) % dqu_pkg::DEPTH;
                     fill--;
                  end
               end
            end
            default: ;
         endcase
         r.count = 5'(fill);
         r.empty_res = (fill == 0);
         awaited_replies.push_back(r);
      endfunction

      function void check_response(logic signed [31:0] data, logic [4:0] count,
                                   logic empty_res, logic [1:0] status);
         reply_type r;
         if (awaited_replies.size() == 0) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display("unexpected response: data %0d count %0d empty %0b status %0d",
                        data, count, empty_res, status);
            return;
         end
         r = awaited_replies.pop_front();
         if (data !== r.data || count !== r.count || empty_res !== r.empty_res ||
             status !== r.status) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display({"mismatch: expected data %0d count %0d empty %0b status %0d,",
                         " got data %0d count %0d empty %0b status %0d"},
                        r.data, r.count, r.empty_res, r.status,
                        data, count, empty_res, status);
         end
      endfunction
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [2:0]         req_action = '0;
   logic signed [31:0] req_value = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [31:0] rsp_data;
   logic [4:0]         rsp_count;
   logic               rsp_empty_res;
   logic [1:0]         rsp_status;

   deque_mirror board = new();

   int unsigned cycles = 0;
   int          idle_pct = 0;
   int          stall_pct = 0;
   int          hold_asks = 0;
   int          hold_served = 0;
   int          hold_left = 0;

   double_ended_queue_unit dut (.*);

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         board.check_response(rsp_data, rsp_count, rsp_empty_res, rsp_status);
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_asks != hold_served) begin
         hold_served <= hold_asks;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   task automatic offer_request(input logic [2:0] action, input logic signed [31:0] value);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_action <= action;
      req_value <= value;
      do @(posedge clock); while (req_stall);
      board.note_request(action, value);
   endtask

   task automatic drain_replies();
      req_valid <= 1'b0;
      while (board.awaited_replies.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   function automatic logic signed [31:0] pick_value();
      case ($urandom_range(9))
         0: return 32'sh7fffffff;
         1: return 32'sh80000000;
         2: return 32'sh0;
         3: return -32'sd1;
         default: return 32'($urandom());
      endcase
   endfunction

   int idle_table [4] = '{0, 68, 0, 30};
   int stall_table [4] = '{0, 0, 68, 30};

   initial begin
      int         n;
      int         burst_len;
      int         push_pct;
      logic [2:0] action;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // underflow on empty, spare codes, extremes, fill to overflow, then pops
      offer_request(dqu_pkg::ACT_POP_TAIL, pick_value());
      offer_request(dqu_pkg::ACT_POP_HEAD, pick_value());
      offer_request(dqu_pkg::ACT_PEEK_TAIL, pick_value());
      offer_request(dqu_pkg::ACT_PEEK_HEAD, pick_value());
      offer_request(ACT_SPARE_A, pick_value());
      offer_request(dqu_pkg::ACT_PUSH_TAIL, 32'sh7fffffff);
      offer_request(dqu_pkg::ACT_PUSH_HEAD, 32'sh80000000);
      offer_request(dqu_pkg::ACT_PEEK_TAIL, 32'sh0);
      offer_request(dqu_pkg::ACT_PEEK_HEAD, 32'sh0);
      offer_request(ACT_SPARE_B, -32'sd1);
      for (int i = 0; i < dqu_pkg::DEPTH - 2; i++)
         offer_request(((i % 2) != 0) ? dqu_pkg::ACT_PUSH_HEAD : dqu_pkg::ACT_PUSH_TAIL,
                       pick_value());
      offer_request(dqu_pkg::ACT_PUSH_TAIL, pick_value());
      offer_request(dqu_pkg::ACT_PUSH_HEAD, pick_value());
      offer_request(dqu_pkg::ACT_POP_TAIL, pick_value());
      offer_request(dqu_pkg::ACT_POP_HEAD, pick_value());
      drain_replies();

      for (int p = 0; p < 4; p++) begin
         idle_pct <= idle_table[p];
         stall_pct <= stall_table[p];
         n = 0;
         while (n < PHASE_ITEMS) begin
            burst_len = $urandom_range(4, 40);
            push_pct = 10 + 40 * $urandom_range(2);
            for (int k = 0; k < burst_len && n < PHASE_ITEMS; k++) begin
               if ($urandom_range(99) < 3) begin
                  action = 3'($urandom_range(ACT_SPARE_A, ACT_SPARE_B));
               end else begin
                  if ($urandom_range(99) < push_pct)
                     action = 3'($urandom_range(dqu_pkg::ACT_PUSH_TAIL,
                                                dqu_pkg::ACT_PUSH_HEAD));
                  else
                     action = 3'($urandom_range(dqu_pkg::ACT_POP_TAIL,
                                                dqu_pkg::ACT_PEEK_HEAD));
                  n++;
               end
               if (p == 0 && n >= 100 && hold_asks == 0)
                  hold_asks <= hold_asks + 1;
               offer_request(action, pick_value());
            end
         end
         drain_replies();
      end

      repeat (10) @(posedge clock);
      if (board.errors == 0 && board.awaited_replies.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end
endmodule

// ===== filelist.f =====
rtl/core/dqu_pkg.sv
rtl/core/dqu_cell.sv
rtl/core/double_ended_queue_unit.sv
tb/testbench.sv
